// ===== design/ddo_pkg.sv =====
package ddo_pkg;

    // field and datapath widths
    localparam int ANGLE_W   = 32;
    localparam int STAMP_W   = 32;
    localparam int SPEED_W   = 32;
    localparam int CFG_W     = 16;
    localparam int DELTA_W   = ANGLE_W + 1;     // exact angle delta
    localparam int MAG_W     = ANGLE_W + 2;     // |dR +/- dL|
    localparam int COEF_W    = 36;              // radius * 1e6 fits here
    localparam int CHUNK_W   = MAG_W / 2;       // multiplier operand slice
    localparam int PP_W      = COEF_W + CHUNK_W;
    localparam int NUM_W     = COEF_W + MAG_W;  // full numerator product
    localparam int DEN_W     = CFG_W + STAMP_W; // separation * dt
    localparam int Q_W       = SPEED_W;
    localparam int HI_W      = NUM_W - Q_W;
    localparam int CNT_W     = $clog2(Q_W);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATION = 1'd1;

    localparam logic [CFG_W-1:0] RADIUS_RST     = 16'd2163;   // 0.033 m
    localparam logic [CFG_W-1:0] SEPARATION_RST = 16'd11141;  // 0.17 m

    // us -> s and Q16.16 scaling folded into constants
    localparam logic [19:0] LIN_K     = 20'd15625;
    localparam logic [19:0] ANG_K     = 20'd1000000;
    localparam int          LIN_SHIFT = 11;

    localparam logic [Q_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic done;
        logic ovf;
    } t_div_stat;

endpackage

// ===== design/ddo_div.sv =====
module ddo_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ddo_pkg::NUM_W-1:0] i_num,
    input  logic [ddo_pkg::DEN_W-1:0] i_den,
    output logic [ddo_pkg::Q_W-1:0]   o_quot,
    output ddo_pkg::t_div_stat        o_stat
);
    import ddo_pkg::*;

    logic             r_run;
    logic             r_done;
    logic             r_ovf;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [Q_W-1:0]   r_low;
    logic [Q_W-1:0]   r_q;

    logic [HI_W-1:0]  w_hi;
    logic             w_hi_ovf;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    // quotient fits 32 bits only if num / 2^32 < den
    assign w_hi     = i_num[NUM_W-1:Q_W];
    assign w_hi_ovf = DEN_W'(w_hi) >= i_den;

    assign w_trial = {r_rem, r_low[Q_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den <= i_den;
                r_rem <= DEN_W'(w_hi);
                r_low <= i_num[Q_W-1:0];
                r_q   <= '0;
                r_cnt <= '0;
                if (i_num == '0) begin
                    r_ovf  <= 1'b0;
                    r_done <= 1'b1;
                end else if (w_hi_ovf) begin
                    r_ovf  <= 1'b1;
                    r_done <= 1'b1;
                end else begin
                    r_ovf <= 1'b0;
                    r_run <= 1'b1;
                end
            end else if (r_run) begin
                r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_low <= r_low << 1;
                r_q   <= {r_q[Q_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(Q_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot      = r_q;
    assign o_stat.done = r_done;
    assign o_stat.ovf  = r_ovf;

endmodule

// ===== design/diff_drive_odometry_velocity_top.sv =====
// Channel   Direction  Handshake               Payload
// in        sink       i_in_valid / o_in_stall   left_angle, right_angle, stamp_us
// out       source     o_out_valid / i_out_stall linear_speed, angular_speed, zero_interval, clipped
// cfg       sink       i_cfg_valid / o_cfg_ready cfg_index, cfg_data
//
// One item at a time: two passes, linear then angular, each bound by the shared
// 32-step radix-2 divider; a pass ends early when its numerator is zero or the
// quotient overflows, and a zero dt skips both passes.
// Synchronous active-low reset clears the sequencer, the previous sample and
// restores the default wheel geometry.
// The result sits in an output register; a stalled result holds the sequencer
// in its final state only when the next result is ready before it is taken.
module diff_drive_odometry_velocity_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [ddo_pkg::ANGLE_W-1:0]  i_left_angle,
    input  logic signed [ddo_pkg::ANGLE_W-1:0]  i_right_angle,
    input  logic        [ddo_pkg::STAMP_W-1:0]  i_stamp_us,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [ddo_pkg::SPEED_W-1:0]  o_linear_speed,
    output logic signed [ddo_pkg::SPEED_W-1:0]  o_angular_speed,
    output logic                                o_zero_interval,
    output logic                                o_clipped,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic        [ddo_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic        [ddo_pkg::CFG_W-1:0]    i_cfg_data
);
    import ddo_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_COEF   = 3'd1;
    localparam logic [2:0] S_MUL0   = 3'd2;
    localparam logic [2:0] S_MUL1   = 3'd3;
    localparam logic [2:0] S_MUL2   = 3'd4;
    localparam logic [2:0] S_DSTART = 3'd5;
    localparam logic [2:0] S_DWAIT  = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    logic [2:0]         r_state;
    logic               r_phase;    // 0: linear, 1: angular
    logic [CFG_W-1:0]   r_wheel_radius;
    logic [CFG_W-1:0]   r_wheel_separation;
    logic [ANGLE_W-1:0] r_last_left;
    logic [ANGLE_W-1:0] r_last_right;
    logic [STAMP_W-1:0] r_last_stamp;

    logic [STAMP_W-1:0] r_dt;
    logic [MAG_W-1:0]   r_lin_mag;
    logic               r_lin_neg;
    logic [MAG_W-1:0]   r_ang_mag;
    logic               r_ang_neg;
    logic [COEF_W-1:0]  r_coef;
    logic [DEN_W-1:0]   r_den;
    logic [PP_W-1:0]    r_pp;
    logic [NUM_W-1:0]   r_acc;
    logic [SPEED_W-1:0] r_lin;
    logic [SPEED_W-1:0] r_ang;
    logic               r_zero;
    logic               r_clip;

    logic               r_out_valid;
    logic [SPEED_W-1:0] r_out_lin;
    logic [SPEED_W-1:0] r_out_ang;
    logic               r_out_zero;
    logic               r_out_clip;

    logic               w_in_take;
    logic               w_out_take;
    logic               w_out_load;
    logic [DELTA_W-1:0] w_dl;
    logic [DELTA_W-1:0] w_dr;
    logic [MAG_W-1:0]   w_sum;
    logic [MAG_W-1:0]   w_diff;
    logic [STAMP_W-1:0] w_dt;
    logic [MAG_W-1:0]   w_mag;
    logic               w_neg;
    logic [CHUNK_W-1:0] w_chunk;
    logic [PP_W-1:0]    w_pp;
    logic               w_div_start;
    logic [Q_W-1:0]     w_quot;
    t_div_stat          w_div_stat;
    logic [Q_W-1:0]     w_limit;
    logic               w_sat;
    logic [Q_W-1:0]     w_qsat;
    logic [Q_W-1:0]     w_res;

    assign w_in_take  = i_in_valid && !o_in_stall;
    assign w_out_take = r_out_valid && !i_out_stall;
    assign w_out_load = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    assign w_dl  = {i_left_angle[ANGLE_W-1], i_left_angle}
                 - {r_last_left[ANGLE_W-1], r_last_left};
    assign w_dr  = {i_right_angle[ANGLE_W-1], i_right_angle}
                 - {r_last_right[ANGLE_W-1], r_last_right};
    assign w_sum  = {w_dr[DELTA_W-1], w_dr} + {w_dl[DELTA_W-1], w_dl};
    assign w_diff = {w_dr[DELTA_W-1], w_dr} - {w_dl[DELTA_W-1], w_dl};
    assign w_dt   = i_stamp_us - r_last_stamp;

    assign w_mag   = r_phase ? r_ang_mag : r_lin_mag;
    assign w_neg   = r_phase ? r_ang_neg : r_lin_neg;
    // one shared 36x17 multiplier, low slice then high slice
    assign w_chunk = (r_state == S_MUL0) ? w_mag[CHUNK_W-1:0]
                                         : w_mag[MAG_W-1:CHUNK_W];
    assign w_pp    = PP_W'(r_coef) * PP_W'(w_chunk);

    assign w_div_start = (r_state == S_DSTART);

    ddo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_acc),
        .i_den   (r_den),
        .o_quot  (w_quot),
        .o_stat  (w_div_stat)
    );

    assign w_limit = w_neg ? SAT_NEG : SAT_POS;
    assign w_sat   = w_div_stat.ovf || (w_quot > w_limit);
    assign w_qsat  = w_sat ? w_limit : w_quot;
    assign w_res   = w_neg ? (Q_W'(0) - w_qsat) : w_qsat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= S_IDLE;
            r_phase            <= 1'b0;
            r_wheel_radius     <= RADIUS_RST;
            r_wheel_separation <= SEPARATION_RST;
            r_last_left        <= '0;
            r_last_right       <= '0;
            r_last_stamp       <= '0;
            r_out_valid        <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_RADIUS) begin
                    r_wheel_radius <= i_cfg_data;
                end else if (i_cfg_index == CFG_SEPARATION) begin
                    r_wheel_separation <= i_cfg_data;
                end
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_take) begin
                        r_last_left  <= i_left_angle;
                        r_last_right <= i_right_angle;
                        r_last_stamp <= i_stamp_us;
                        r_dt         <= w_dt;
                        r_lin_neg    <= w_sum[MAG_W-1];
                        r_lin_mag    <= w_sum[MAG_W-1] ? (MAG_W'(0) - w_sum) : w_sum;
                        r_ang_neg    <= w_diff[MAG_W-1];
                        r_ang_mag    <= w_diff[MAG_W-1] ? (MAG_W'(0) - w_diff) : w_diff;
                        r_lin        <= '0;
                        r_ang        <= '0;
                        r_clip       <= 1'b0;
                        r_zero       <= (w_dt == '0);
                        r_phase      <= 1'b0;
                        r_state      <= (w_dt == '0) ? S_FIN : S_COEF;
                    end
                end
                S_COEF: begin
                    if (r_phase) begin
                        r_coef <= COEF_W'(r_wheel_radius) * COEF_W'(ANG_K);
                        r_den  <= DEN_W'(r_wheel_separation) * DEN_W'(r_dt);
                    end else begin
                        r_coef <= COEF_W'(r_wheel_radius) * COEF_W'(LIN_K);
                        r_den  <= DEN_W'(r_dt) << LIN_SHIFT;
                    end
                    r_state <= S_MUL0;
                end
                S_MUL0: begin
                    r_pp    <= w_pp;
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_acc   <= NUM_W'(r_pp);
                    r_pp    <= w_pp;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_acc   <= r_acc + (NUM_W'(r_pp) << CHUNK_W);
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (w_div_stat.done) begin
                        r_clip <= r_clip | w_sat;
                        if (r_phase) begin
                            r_ang   <= w_res;
                            r_state <= S_FIN;
                        end else begin
                            r_lin   <= w_res;
                            r_phase <= 1'b1;
                            r_state <= S_COEF;
                        end
                    end
                end
                S_FIN: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_lin  <= r_lin;
            r_out_ang  <= r_ang;
            r_out_zero <= r_zero;
            r_out_clip <= r_clip;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_linear_speed  = r_out_lin;
    assign o_angular_speed = r_out_ang;
    assign o_zero_interval = r_out_zero;
    assign o_clipped       = r_out_clip;

    a_zero_gives_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_interval) |->
            (o_linear_speed == '0 && o_angular_speed == '0 && !o_clipped))
        else $error("zero interval result with nonzero speed or clip");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> o_in_stall)
        else $error("input taken but sequencer not busy");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_DWAIT))
        else $error("divider finished outside wait state");

    a_start_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> !w_div_start)
        else $error("divider started twice in a row");

endmodule

// ===== bench/diff_drive_odometry_velocity_top_tb.sv =====
module diff_drive_odometry_velocity_top_tb;

    localparam int          LIMIT_CYCLES    = 1_500_000;
    localparam int          RANDOM_PER_PASS = 450;
    localparam int          STEP_MAX        = 262144;   // 4 rad in Q16.16
    localparam logic [63:0] LIN_SCALE       = 64'd15625;
    localparam logic [63:0] ANG_SCALE       = 64'd1000000;

    typedef struct packed {
        logic [31:0] linear;
        logic [31:0] angular;
        logic        zero_dt;
        logic        clip;
    } t_speed;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    logic signed [31:0] i_left_angle;
    logic signed [31:0] i_right_angle;
    logic [31:0] i_stamp_us;
    logic o_out_valid;
    logic i_out_stall;
    logic signed [31:0] o_linear_speed;
    logic signed [31:0] o_angular_speed;
    logic o_zero_interval;
    logic o_clipped;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [ddo_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [ddo_pkg::CFG_W-1:0] i_cfg_data;

    diff_drive_odometry_velocity_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_left_angle    (i_left_angle),
        .i_right_angle   (i_right_angle),
        .i_stamp_us      (i_stamp_us),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_linear_speed  (o_linear_speed),
        .o_angular_speed (o_angular_speed),
        .o_zero_interval (o_zero_interval),
        .o_clipped       (o_clipped),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // predictor state
    logic signed [31:0] prev_left;
    logic signed [31:0] prev_right;
    logic [31:0] prev_stamp;
    logic [15:0] radius_q16;
    logic [15:0] separation_q16;

    t_speed pending_speeds[$];
    int errors;
    int samples_sent;
    int speeds_checked;
    int reg_writes;
    int zero_dt_seen;
    int clipped_seen;
    int cycle_count;
    // idle chance per cycle, in percent
    int snd_idle_pct;
    int rcv_idle_pct;

    // bit 32 flags saturation, low bits are the signed quotient
    function automatic logic [32:0] scaled_speed(input logic [63:0] coef,
                                                 input logic signed [35:0] num,
                                                 input logic [63:0] den);
        logic neg;
        logic [35:0] mag;
        logic [127:0] quot;
        logic [31:0] lim;
        logic [31:0] q;
        logic sat;
        neg = num[35];
        mag = neg ? -num : num;
        lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        sat = 1'b0;
        if (coef == 0 || mag == 0)
            return '0;
        if (den == 0) begin
            sat = 1'b1;
            q = lim;
        end else begin
            quot = (128'(coef) * 128'(mag)) / 128'(den);
            if (quot > 128'(lim)) begin
                sat = 1'b1;
                q = lim;
            end else begin
                q = quot[31:0];
            end
        end
        return {sat, neg ? -q : q};
    endfunction

    function automatic t_speed predict_speeds(input logic signed [31:0] left,
                                              input logic signed [31:0] right,
                                              input logic [31:0] stamp);
        logic signed [35:0] dl;
        logic signed [35:0] dr;
        logic [31:0] dt;
        logic [32:0] lin_r;
        logic [32:0] ang_r;
        t_speed res;
        dl = left - prev_left;
        dr = right - prev_right;
        dt = stamp - prev_stamp;
        prev_left = left;
        prev_right = right;
        prev_stamp = stamp;
        res = '0;
        if (dt == 0) begin
            res.zero_dt = 1'b1;
        end else begin
            lin_r = scaled_speed(64'(radius_q16) * LIN_SCALE, dr + dl, 64'(dt) << 11);
            ang_r = scaled_speed(64'(radius_q16) * ANG_SCALE, dr - dl,
                                 64'(separation_q16) * 64'(dt));
            res.linear = lin_r[31:0];
            res.angular = ang_r[31:0];
            res.clip = lin_r[32] | ang_r[32];
        end
        return res;
    endfunction

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_speed got;
        t_speed want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_linear_speed, o_angular_speed, o_zero_interval, o_clipped};
            if (pending_speeds.size() == 0) begin
                errors++;
                $display("%0t: unexpected result lin %h ang %h zero %b clip %b",
                         $time, got.linear, got.angular, got.zero_dt, got.clip);
            end else begin
                want = pending_speeds.pop_front();
                speeds_checked++;
                zero_dt_seen += want.zero_dt;
                clipped_seen += want.clip;
                if (got !== want) begin
                    errors++;
                    $display({"%0t: mismatch lin exp %h got %h, ang exp %h got %h, ",
                              "zero exp %b got %b, clip exp %b got %b"},
                             $time, want.linear, got.linear, want.angular, got.angular,
                             want.zero_dt, got.zero_dt, want.clip, got.clip);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_speeds.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_sample(input logic [31:0] left, input logic [31:0] right,
                               input logic [31:0] stamp);
        bit idled;
        idled = 0;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            if (!idled)
                i_in_valid <= 1'b0;
            idled = 1;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_left_angle <= left;
        i_right_angle <= right;
        i_stamp_us <= stamp;
        do @(posedge i_clk); while (o_in_stall);
        pending_speeds.insert(pending_speeds.size(), predict_speeds(left, right, stamp));
        samples_sent++;
    endtask

    // stop input and let every outstanding result come back
    task automatic drain;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_speeds.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [ddo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == ddo_pkg::CFG_RADIUS)
            radius_q16 = data;
        else
            separation_q16 = data;
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_sample;
        int kind;
        int dl;
        int dr;
        logic [31:0] left;
        logic [31:0] right;
        logic [31:0] stamp;
        kind = $urandom_range(0, 9);
        dl = int'($urandom_range(0, 2 * STEP_MAX)) - STEP_MAX;
        dr = int'($urandom_range(0, 2 * STEP_MAX)) - STEP_MAX;
        case (kind)
            0: begin
                left = $urandom;
                right = $urandom;
                stamp = $urandom;
            end
            1: begin
                left = $urandom;
                right = $urandom;
                stamp = prev_stamp;
            end
            2: begin
                left = prev_left + dl;
                right = prev_right + dr;
                stamp = prev_stamp + $urandom_range(1, 8);
            end
            default: begin
                left = prev_left + dl;
                right = prev_right + dr;
                stamp = prev_stamp + $urandom_range(200, 40000);
            end
        endcase
        send_sample(left, right, stamp);
    endtask

    // reset geometry: zero interval, zero and opposite deltas, extremes, wrap
    task automatic test_reset_geometry;
        send_sample(32'h0, 32'h0, 32'd0);
        send_sample(32'h0001_0000, 32'h0002_0000, 32'd10000);
        send_sample(32'h0001_0000, 32'h0003_0000, 32'd10000);
        send_sample(32'h0001_0000, 32'h0003_0000, 32'd20000);
        send_sample(32'h0002_0000, 32'h0004_0000, 32'd21000);
        send_sample(32'h0001_0000, 32'h0005_0000, 32'd22000);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'd22001);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'd22002);
        send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFF0);
        send_sample(32'h7FFF_FFF0, 32'h7FFF_FFF8, 32'h0000_0010);
        send_sample(32'h8000_0010, 32'hFFFF_FFFF, 32'h0000_000F);
        drain();
    endtask

    // zero radius, zero separation and the register extremes
    task automatic test_geometry_extremes;
        write_reg(ddo_pkg::CFG_RADIUS, 16'd0);
        send_sample(32'h0001_0000, 32'h0002_0000, 32'h1000);
        drain();
        write_reg(ddo_pkg::CFG_RADIUS, 16'hFFFF);
        write_reg(ddo_pkg::CFG_SEPARATION, 16'd0);
        send_sample(32'h0002_0000, 32'h0004_0000, 32'h2000);
        send_sample(32'h0003_0000, 32'h0005_0000, 32'h3000);
        send_sample(32'h0002_0000, 32'h0006_0000, 32'h4000);
        send_sample(32'h0004_0000, 32'h0004_0000, 32'h5000);
        drain();
        write_reg(ddo_pkg::CFG_RADIUS, 16'd1);
        write_reg(ddo_pkg::CFG_SEPARATION, 16'hFFFF);
        send_sample(32'h0004_8000, 32'h0003_0000, 32'h6000);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h6001);
        drain();
        write_reg(ddo_pkg::CFG_RADIUS, 16'hFFFF);
        write_reg(ddo_pkg::CFG_SEPARATION, 16'd1);
        send_sample(32'h8001_0000, 32'h7FFE_8000, 32'h7000);
        send_sample(32'h8000_F000, 32'h7FFE_9000, 32'h9000);
        drain();
    endtask

    // random traffic under each idling mode and a different geometry per pass
    task automatic test_random_traffic;
        for (int pass = 0; pass < 4; pass++) begin
            case (pass)
                0: begin
                    write_reg(ddo_pkg::CFG_RADIUS, 16'd2163);
                    write_reg(ddo_pkg::CFG_SEPARATION, 16'd11141);
                end
                1: begin
                    write_reg(ddo_pkg::CFG_RADIUS, 16'($urandom_range(1, 65535)));
                    write_reg(ddo_pkg::CFG_SEPARATION, 16'($urandom_range(1, 65535)));
                end
                2: begin
                    write_reg(ddo_pkg::CFG_RADIUS, 16'd1);
                    write_reg(ddo_pkg::CFG_SEPARATION, 16'hFFFF);
                end
                default: begin
                    write_reg(ddo_pkg::CFG_RADIUS, 16'($urandom_range(500, 8000)));
                    write_reg(ddo_pkg::CFG_SEPARATION, 16'($urandom_range(2000, 40000)));
                end
            endcase
            // pass 0 no idling, 1 sender only, 2 receiver only, 3 both at a light rate
            case (pass)
                0: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
                1: begin
                    snd_idle_pct = 59;
                    rcv_idle_pct = 0;
                end
                2: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 59;
                end
                default: begin
                    snd_idle_pct = 16;
                    rcv_idle_pct = 16;
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PASS; n++)
                send_random_sample();
            drain();
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_left_angle = '0;
        i_right_angle = '0;
        i_stamp_us = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = ddo_pkg::CFG_RADIUS;
        i_cfg_data = '0;
        prev_left = '0;
        prev_right = '0;
        prev_stamp = '0;
        radius_q16 = 16'd2163;
        separation_q16 = 16'd11141;
        errors = 0;
        samples_sent = 0;
        speeds_checked = 0;
        reg_writes = 0;
        zero_dt_seen = 0;
        clipped_seen = 0;
        cycle_count = 0;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_geometry();
        test_geometry_extremes();
        test_random_traffic();

        drain();
        repeat (100) @(posedge i_clk);
        if (pending_speeds.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, pending_speeds.size());
        end
        $display("Sent %0d wheel samples and checked %0d speed results",
                 samples_sent, speeds_checked);
        $display("over %0d register writes; %0d had a zero interval and %0d saturated.",
                 reg_writes, zero_dt_seen, clipped_seen);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
